### hdl/egarch_pkg.sv
package egarch_pkg;

   localparam int SAMPLE_W = 32;
   localparam int HVAR_W   = 23;
   localparam int Z_W      = 24;
   localparam int TERM_W   = 32;
   localparam int TOTAL_W  = 41;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int ACC_W    = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA1   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA2   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_H  = 3'd7;

   localparam logic signed [24:0] EABS_Q16     = 25'sd52290;
   localparam logic signed [23:0] LOG2PI_Q16   = 24'sd120447;
   localparam logic signed [33:0] H_LIMIT      = 34'sd3276800;
   localparam logic signed [39:0] INV_2LN2_Q16 = 40'sd47274;
   localparam logic [63:0]        LN2_Q30      = 64'd744261118;
   localparam logic [71:0]        Z_POS_LIMIT  = 72'd8388607;
   localparam logic [71:0]        Z_NEG_LIMIT  = 72'd8388608;
   localparam logic signed [TOTAL_W-1:0] NLL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
   localparam logic signed [TOTAL_W-1:0] NLL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

   typedef struct packed {
      logic signed [23:0] omega;
      logic signed [19:0] alpha1;
      logic signed [19:0] alpha2;
      logic signed [19:0] gamma1;
      logic signed [19:0] gamma2;
      logic signed [16:0] beta1;
      logic signed [16:0] beta2;
      logic signed [22:0] init_h;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       start;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_HCLAMP,
      ST_XMUL,
      ST_LOOKUP,
      ST_PROD,
      ST_SHIFT,
      ST_SQUARE,
      ST_ACCUM
   } state_type;

endpackage

### hdl/egarch_log_variance_filter_unit.sv
// The back-end sequencer takes one sample at a time from the front queue; its shared
// multiply-accumulate takes one lag term a cycle (ST_MAC), followed by ST_HCLAMP, ST_XMUL,
// exp lookup, ST_PROD, ST_SHIFT, squaring and ST_ACCUM, which waits for a free output slot.
// Reset: synchronous, active high; clears queue, lag history, running sum, CSRs and output valid.
module egarch_log_variance_filter_unit #(
   parameter int LAG_DEPTH         = 2,
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [31:0]  req_return_sample,
   input  logic                req_series_start,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [22:0]  rsp_log_variance,
   output logic signed [23:0]  rsp_std_residual,
   output logic                rsp_residual_saturated,
   output logic signed [31:0]  rsp_nll_term,
   output logic signed [40:0]  rsp_nll_total,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_write_data
);
   import egarch_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type item;
   logic     item_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OMEGA:  cfg_in.omega  = csr_write_data[23:0];
            CSR_ALPHA1: cfg_in.alpha1 = csr_write_data[19:0];
            CSR_ALPHA2: cfg_in.alpha2 = csr_write_data[19:0];
            CSR_GAMMA1: cfg_in.gamma1 = csr_write_data[19:0];
            CSR_GAMMA2: cfg_in.gamma2 = csr_write_data[19:0];
            CSR_BETA1:  cfg_in.beta1  = csr_write_data[16:0];
            CSR_BETA2:  cfg_in.beta2  = csr_write_data[16:0];
            CSR_INIT_H: cfg_in.init_h = csr_write_data[22:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   egarch_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_return_sample (req_return_sample),
      .req_series_start  (req_series_start),
      .item              (item),
      .item_pop          (item_pop)
   );

   egarch_back #(
      .LAG_DEPTH         (LAG_DEPTH),
      .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .item                   (item),
      .item_pop               (item_pop),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_log_variance       (rsp_log_variance),
      .rsp_std_residual       (rsp_std_residual),
      .rsp_residual_saturated (rsp_residual_saturated),
      .rsp_nll_term           (rsp_nll_term),
      .rsp_nll_total          (rsp_nll_total)
   );

   a_rsp_drop_on_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !$past(rsp_empty)) |-> $past(rsp_pop))
      else $error("result vanished without a pop");

   a_h_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_log_variance <= 23'sd3276800 && rsp_log_variance >= -23'sd3276800))
      else $error("log variance outside clamp");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_residual_saturated) |->
      (rsp_std_residual == 24'sd8388607 || rsp_std_residual == -24'sd8388608))
      else $error("saturation flag without saturated residual");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item.valid)
      else $error("back end popped an empty queue");

endmodule

### hdl/egarch_front.sv
module egarch_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [31:0]  req_return_sample,
   input  logic                req_series_start,
   output egarch_pkg::item_type item,
   input  logic                item_pop
);
   import egarch_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff [2];
   logic                       start_ff  [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign req_full = (count_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign do_pop   = item_pop && (count_ff != 2'd0);

   assign item.valid  = (count_ff != 2'd0);
   assign item.sample = sample_ff[rd_ptr_ff];
   assign item.start  = start_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         sample_ff[wr_ptr_ff] <= req_return_sample;
         start_ff[wr_ptr_ff]  <= req_series_start;
      end
   end

endmodule

### hdl/egarch_back.sv
module egarch_back #(
   parameter int LAG_DEPTH         = 2,
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  egarch_pkg::cfg_type  cfg,
   input  egarch_pkg::item_type item,
   output logic                 item_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [22:0]   rsp_log_variance,
   output logic signed [23:0]   rsp_std_residual,
   output logic                 rsp_residual_saturated,
   output logic signed [31:0]   rsp_nll_term,
   output logic signed [40:0]   rsp_nll_total
);
   import egarch_pkg::*;

   localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
   localparam logic [2:0] LAST_STEP = 3'(3 * LAG_DEPTH - 1);

   localparam logic [63:0] RECIP_NUM = 64'd1 << 36;
   localparam logic [63:0] RECIP_K [15] = '{
      64'd0,
      RECIP_NUM,
      (RECIP_NUM + 64'd1) / 64'd2,
      (RECIP_NUM + 64'd2) / 64'd3,
      (RECIP_NUM + 64'd3) / 64'd4,
      (RECIP_NUM + 64'd4) / 64'd5,
      (RECIP_NUM + 64'd5) / 64'd6,
      (RECIP_NUM + 64'd6) / 64'd7,
      (RECIP_NUM + 64'd7) / 64'd8,
      (RECIP_NUM + 64'd8) / 64'd9,
      (RECIP_NUM + 64'd9) / 64'd10,
      (RECIP_NUM + 64'd10) / 64'd11,
      (RECIP_NUM + 64'd11) / 64'd12,
      (RECIP_NUM + 64'd12) / 64'd13,
      (RECIP_NUM + 64'd13) / 64'd14
   };

   typedef logic [16:0] exp_table_type [EXP_TABLE_ENTRIES];

   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      logic [63:0]   y;
      logic [63:0]   term;
      logic [63:0]   sum;
      logic [127:0]  wide;
      for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
         y    = (64'(i) * LN2_Q30) >> IDX_W;
         term = 64'd1 << 30;
         sum  = 64'd1 << 30;
         for (int k = 1; k <= 14; k++) begin
            wide = 128'((term * y) >> 30) * 128'(RECIP_K[k]);
            term = 64'(wide >> 36);
            sum  = sum + term;
         end
         t[i] = 17'((sum + 64'd8192) >> 14);
      end
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

   state_type state_ff, state_in;

   logic signed [HVAR_W-1:0]  hlag_ff [2];
   logic signed [Z_W-1:0]     zlag_ff [2];
   logic [1:0]                seen_ff;
   logic signed [TOTAL_W-1:0] nll_ff;

   logic signed [SAMPLE_W-1:0] r_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [2:0]                 step_ff;
   logic signed [HVAR_W-1:0]   h_ff, h_in;
   logic signed [7:0]          n_ff;
   logic [15:0]                f_ff;
   logic [16:0]                entry_ff;
   logic [48:0]                p_ff;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic                       sat_ff, sat_in;
   logic signed [TERM_W-1:0]   term_ff, term_in;

   logic out_valid_ff;
   logic slot_free;
   logic out_load;

   logic signed [Z_W-1:0]    z1, z2;
   logic signed [HVAR_W-1:0] hl1, hl2;
   logic signed [24:0]       z1_x, z2_x, abs1, abs2;
   logic signed [19:0]       op_a;
   logic signed [24:0]       op_b;
   logic signed [44:0]       prod;

   logic signed [ACC_W-1:0]  acc_r;
   logic signed [33:0]       hr;
   logic signed [39:0]       hm, x40;
   logic [31:0]              fe;
   logic [IDX_W-1:0]         idx;
   logic [31:0]              mag;
   logic signed [8:0]        s;
   logic [71:0]              q, lim, qq;
   logic                     neg;
   logic signed [47:0]       zz;
   logic signed [23:0]       hb;
   logic signed [ACC_W-1:0]  total;
   logic signed [41:0]       sum42;
   logic signed [TOTAL_W-1:0] sum_sat;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (item.valid) state_in = ST_MAC;
         ST_MAC:    if (step_ff == LAST_STEP) state_in = ST_HCLAMP;
         ST_HCLAMP: state_in = ST_XMUL;
         ST_XMUL:   state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_PROD;
         ST_PROD:   state_in = ST_SHIFT;
         ST_SHIFT:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_pop = (state_ff == ST_IDLE) && item.valid;
      out_load = (state_ff == ST_ACCUM) && slot_free;
   end

   always_comb begin
      z1   = (seen_ff >= 2'd1) ? zlag_ff[0] : '0;
      hl1  = (seen_ff >= 2'd1) ? hlag_ff[0] : cfg.init_h;
      z2   = (seen_ff >= 2'd2) ? zlag_ff[1] : '0;
      hl2  = (seen_ff >= 2'd2) ? hlag_ff[1] : cfg.init_h;
      z1_x = {z1[Z_W-1], z1};
      z2_x = {z2[Z_W-1], z2};
      abs1 = z1_x[24] ? -z1_x : z1_x;
      abs2 = z2_x[24] ? -z2_x : z2_x;
      unique case (step_ff)
         3'd0: begin op_a = cfg.alpha1;   op_b = abs1 - EABS_Q16; end
         3'd1: begin op_a = cfg.gamma1;   op_b = z1_x; end
         3'd2: begin op_a = 20'(cfg.beta1); op_b = 25'(hl1); end
         3'd3: begin op_a = cfg.alpha2;   op_b = abs2 - EABS_Q16; end
         3'd4: begin op_a = cfg.gamma2;   op_b = z2_x; end
         3'd5: begin op_a = 20'(cfg.beta2); op_b = 25'(hl2); end
         default: begin op_a = '0; op_b = '0; end
      endcase
      prod   = 45'(op_a) * 45'(op_b);
      acc_in = acc_ff + {{5{prod[44]}}, prod};
   end

   always_comb begin
      acc_r = acc_ff + 50'sd32768;
      hr    = acc_r[49:16];
      priority if (hr > H_LIMIT)  h_in = 23'(H_LIMIT);
      else if (hr < -H_LIMIT)     h_in = 23'(-H_LIMIT);
      else                        h_in = hr[22:0];
      hm  = 40'(h_ff) * INV_2LN2_Q16;
      x40 = 40'sd32768 - hm;
      fe  = 32'(f_ff) * 32'(EXP_TABLE_ENTRIES);
      idx = fe[16 +: IDX_W];
      neg = r_ff[SAMPLE_W-1];
      mag = neg ? (32'd0 - r_ff) : r_ff;
      s   = 9'sd16 - {n_ff[7], n_ff};
      if (s > 9'sd0)
         q = (72'(p_ff) + (72'd1 << (s[5:0] - 6'd1))) >> s[5:0];
      else
         q = 72'(p_ff) << 6'(-s);
      lim    = neg ? Z_NEG_LIMIT : Z_POS_LIMIT;
      sat_in = (q > lim);
      qq     = sat_in ? lim : q;
      z_in   = neg ? (24'd0 - qq[23:0]) : qq[23:0];
      zz     = 48'(z_ff) * 48'(z_ff);
      hb     = 24'(h_ff) + LOG2PI_Q16;
      total  = {{10{hb[23]}}, hb, 16'd0} + {{2{zz[47]}}, zz} + 50'sd65536;
      term_in = total[48:17];
      sum42  = {nll_ff[TOTAL_W-1], nll_ff} + {{10{term_ff[31]}}, term_ff};
      priority if (sum42[41] != sum42[40]) sum_sat = sum42[41] ? NLL_MIN : NLL_MAX;
      else sum_sat = sum42[40:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         seen_ff      <= 2'd0;
         nll_ff       <= '0;
         hlag_ff[0]   <= '0;
         hlag_ff[1]   <= '0;
         zlag_ff[0]   <= '0;
         zlag_ff[1]   <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load)
            out_valid_ff <= 1'b1;
         else if (rsp_pop)
            out_valid_ff <= 1'b0;
         if (item_pop && item.start) begin
            seen_ff    <= 2'd0;
            nll_ff     <= '0;
            hlag_ff[0] <= '0;
            hlag_ff[1] <= '0;
            zlag_ff[0] <= '0;
            zlag_ff[1] <= '0;
         end else if (out_load) begin
            nll_ff     <= sum_sat;
            hlag_ff[1] <= hlag_ff[0];
            hlag_ff[0] <= h_ff;
            zlag_ff[1] <= zlag_ff[0];
            zlag_ff[0] <= z_ff;
            if (seen_ff != 2'd2) seen_ff <= seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            r_ff    <= item.sample;
            acc_ff  <= {{10{cfg.omega[23]}}, cfg.omega, 16'd0};
            step_ff <= 3'd0;
         end
         ST_MAC: begin
            acc_ff  <= acc_in;
            step_ff <= step_ff + 3'd1;
         end
         ST_HCLAMP: h_ff <= h_in;
         ST_XMUL: begin
            n_ff <= x40[39:32];
            f_ff <= x40[31:16];
         end
         ST_LOOKUP: entry_ff <= EXP_TABLE[idx];
         ST_PROD:   p_ff <= 49'(mag) * 49'(entry_ff);
         ST_SHIFT: begin
            z_ff   <= z_in;
            sat_ff <= sat_in;
         end
         ST_SQUARE: term_ff <= term_in;
         ST_ACCUM: begin
            if (out_load) begin
               rsp_log_variance       <= h_ff;
               rsp_std_residual       <= z_ff;
               rsp_residual_saturated <= sat_ff;
               rsp_nll_term           <= term_ff;
               rsp_nll_total          <= sum_sat;
            end
         end
         default: ;
      endcase
   end

endmodule
